/* src/tomq_pkg.sv */
// Shared types and constants for the timestamp-ordered message queue.
// Used by the cell, the result buffer, the top level and the checker.
// No dependencies.
`default_nettype none

package tomq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int STAMP_W       = 32;
  localparam int OBJECT_W      = 16;
  localparam int OUTLET_W      = 8;
  localparam int MESSAGE_W     = 16;
  localparam int COUNT_W       = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_POP    = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [STAMP_W-1:0]   stamp;
    logic [OBJECT_W-1:0]  object;
    logic [OUTLET_W-1:0]  outlet;
    logic [MESSAGE_W-1:0] message;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic do_insert;
    logic do_match;
    logic do_delete;
  } cell_ctl_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
    entry_t             head;
  } result_t;

endpackage

`default_nettype wire

/* src/tomq_cell.sv */
// One slot of the sorted chain: holds an entry and its valid bit.
// Depends on tomq_pkg for the entry and command types.
`default_nettype none

module tomq_cell (
  input  logic               clk,
  input  logic               rst,
  input  tomq_pkg::cell_ctl_t ctl,
  input  tomq_pkg::entry_t   new_ent,
  input  tomq_pkg::entry_t   left_ent,
  input  logic               left_valid,
  input  logic               left_go,
  input  tomq_pkg::entry_t   right_ent,
  input  logic               right_valid,
  input  logic               del_here,
  output tomq_pkg::entry_t   ent,
  output logic               valid,
  output logic               go,
  output logic               match
);

  logic take_insert;
  logic take_delete;

  // The new entry belongs at or before this slot when the slot is free or
  // holds a strictly later stamp. This is monotonic along the chain.
  assign go          = !valid || (new_ent.stamp < ent.stamp);
  assign take_insert = ctl.do_insert && go;
  assign take_delete = ctl.do_delete && del_here;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take_insert) begin
      valid <= left_go ? left_valid : 1'b1;
    end else if (take_delete) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_insert) begin
      ent <= left_go ? left_ent : new_ent;
    end else if (take_delete) begin
      ent <= right_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_match) begin
      match <= valid && (ent.object == new_ent.object) &&
               (ent.message == new_ent.message) && (ent.outlet == new_ent.outlet);
    end
  end

endmodule

`default_nettype wire

/* src/tomq_result_buf.sv */
// Two-entry result buffer that decouples the queue from the response stall.
// Depends on tomq_pkg for the result type.
`default_nettype none

module tomq_result_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tomq_pkg::result_t push_data,
  input  logic              stall,
  output logic              valid,
  output tomq_pkg::result_t data,
  output logic [1:0]        count
);

  tomq_pkg::result_t skid;
  logic              pop;

  assign pop   = valid && !stall;
  assign valid = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    unique case (count)
      2'd0: begin
        if (push) data <= push_data;
      end
      2'd1: begin
        if (push && pop) begin
          data <= push_data;
        end else if (push) begin
          skid <= push_data;
        end
      end
      2'd2: begin
        if (pop) begin
          data <= skid;
          if (push) skid <= push_data;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/timestamp_ordered_message_queue_top.sv */
// Insert, pop and no-op requests update the queue at the accept edge, a remove in its
// ST_REMOVE state. Results reach the response port through the report stage and buffer.
// One insert, pop or no-op request is taken per cycle while results drain; a remove
// stalls in ST_REMOVE, as its match vector is registered before the prefix network.
// Reset (rst, synchronous) clears every slot valid bit, the count and the result buffer
// at once; slot payloads are not cleared and there is no clearing pass.
`default_nettype none

module timestamp_ordered_message_queue_top #(
  parameter int DEPTH = tomq_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] stamp,
  input  logic [15:0] object_id,
  input  logic [7:0]  outlet_number,
  input  logic [15:0] message_handle,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [1:0]  status,
  output logic [6:0]  entry_count,
  output logic        is_empty,
  output logic [31:0] head_stamp,
  output logic [15:0] head_object,
  output logic [7:0]  head_outlet,
  output logic [15:0] head_message
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int STEPS = $clog2(DEPTH);

  // The sequencer has two states: idle, where requests are taken, and the
  // delete state of a remove, where the first match is deleted.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REMOVE = 2'b10
  } fsm_t;

  fsm_t                 state;
  fsm_t                 state_next;
  logic [CNT_W-1:0]     occupancy;
  logic [CNT_W-1:0]     occupancy_next;
  logic                 report_pending;
  logic                 report_pending_next;
  tomq_pkg::status_t    report_status;
  tomq_pkg::status_t    report_status_next;

  tomq_pkg::cell_ctl_t  ctl;
  tomq_pkg::entry_t     new_ent;
  tomq_pkg::entry_t     cell_ent [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     cell_go;
  logic [DEPTH-1:0]     cell_match;
  logic [DEPTH-1:0]     del_vec;
  logic [DEPTH-1:0]     first_seen;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 found;
  tomq_pkg::opcode_t    op;

  tomq_pkg::result_t    result;
  tomq_pkg::result_t    rsp_data;
  logic [1:0]           buf_count;
  logic [1:0]           held;
  logic [1:0]           busy_slots;
  logic                 drain;
  logic [CNT_W+tomq_pkg::COUNT_W-1:0] cnt_ext;

  assign op    = tomq_pkg::opcode_t'(opcode);
  assign full  = (occupancy == CNT_W'(DEPTH));
  assign empty = (occupancy == '0);

  assign new_ent.stamp   = stamp;
  assign new_ent.object  = object_id;
  assign new_ent.outlet  = outlet_number;
  assign new_ent.message = message_handle;

  // Flow control: every accepted request yields exactly one result, and the
  // buffer has two places. A request is taken only when the results still
  // owed, counting the one about to leave, leave a place for it.
  assign drain      = rsp_valid && !rsp_stall;
  assign held       = buf_count + {1'b0, report_pending};
  assign busy_slots = held - {1'b0, drain};
  assign req_stall  = (state != ST_IDLE) || (busy_slots >= 2'd2);
  assign accept     = req_valid && !req_stall;

  // Chain of cells. Each cell sees its left neighbor for insert shifts and
  // its right neighbor for delete shifts; the ends are tied off.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tomq_pkg::entry_t left_ent;
    tomq_pkg::entry_t right_ent;
    logic             left_valid;
    logic             left_go;
    logic             right_valid;

    if (i == 0) begin : g_first
      assign left_ent   = '0;
      assign left_valid = 1'b1;
      assign left_go    = 1'b0;
    end else begin : g_inner_left
      assign left_ent   = cell_ent[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_go    = cell_go[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent   = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_ent   = cell_ent[i+1];
      assign right_valid = cell_valid[i+1];
    end

    tomq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .new_ent     (new_ent),
      .left_ent    (left_ent),
      .left_valid  (left_valid),
      .left_go     (left_go),
      .right_ent   (right_ent),
      .right_valid (right_valid),
      .del_here    (del_vec[i]),
      .ent         (cell_ent[i]),
      .valid       (cell_valid[i]),
      .go          (cell_go[i]),
      .match       (cell_match[i])
    );
  end

  // Prefix OR over the registered match bits, in log2(DEPTH) doubling steps.
  // A cell deletes itself (taking its right neighbor) when the first match
  // lies at or before it.
  always_comb begin
    first_seen = cell_match;
    for (int k = 0; k < STEPS; k++) begin
      first_seen = first_seen | (first_seen << (1 << k));
    end
  end

  assign found = first_seen[DEPTH-1];

  // Sequencer: decide the broadcast command, the new count and the status
  // that the report stage will return in the following cycle.
  always_comb begin
    state_next          = state;
    occupancy_next      = occupancy;
    report_pending_next = 1'b0;
    report_status_next  = report_status;
    ctl                 = '0;
    del_vec             = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            tomq_pkg::OP_INSERT: begin
              report_pending_next = 1'b1;
              if (full) begin
                report_status_next = tomq_pkg::STS_FULL;
              end else begin
                ctl.do_insert      = 1'b1;
                occupancy_next     = occupancy + 1'b1;
                report_status_next = tomq_pkg::STS_OK;
              end
            end
            tomq_pkg::OP_REMOVE: begin
              ctl.do_match = 1'b1;
              state_next   = ST_REMOVE;
            end
            tomq_pkg::OP_POP: begin
              report_pending_next = 1'b1;
              if (empty) begin
                report_status_next = tomq_pkg::STS_EMPTY;
              end else begin
                ctl.do_delete      = 1'b1;
                del_vec            = '1;
                occupancy_next     = occupancy - 1'b1;
                report_status_next = tomq_pkg::STS_OK;
              end
            end
            tomq_pkg::OP_NOP: begin
              report_pending_next = 1'b1;
              report_status_next  = tomq_pkg::STS_OK;
            end
            default: begin
            end
          endcase
        end
      end
      ST_REMOVE: begin
        state_next          = ST_IDLE;
        report_pending_next = 1'b1;
        if (found) begin
          ctl.do_delete      = 1'b1;
          del_vec            = first_seen;
          occupancy_next     = occupancy - 1'b1;
          report_status_next = tomq_pkg::STS_OK;
        end else begin
          report_status_next = tomq_pkg::STS_NOT_FOUND;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      occupancy      <= '0;
      report_pending <= 1'b0;
    end else begin
      state          <= state_next;
      occupancy      <= occupancy_next;
      report_pending <= report_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    report_status <= report_status_next;
  end

  // Report stage: in the cycle after the queue changes, the head cell and the
  // count already hold the post-operation values and are pushed as the result.
  assign cnt_ext       = (CNT_W + tomq_pkg::COUNT_W)'(occupancy);
  assign result.status = report_status;
  assign result.count  = cnt_ext[tomq_pkg::COUNT_W-1:0];
  assign result.empty  = empty;
  assign result.head   = cell_valid[0] ? cell_ent[0] : '0;

  tomq_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (report_pending),
    .push_data (result),
    .stall     (rsp_stall),
    .valid     (rsp_valid),
    .data      (rsp_data),
    .count     (buf_count)
  );

  assign status       = rsp_data.status;
  assign entry_count  = rsp_data.count;
  assign is_empty     = rsp_data.empty;
  assign head_stamp   = rsp_data.head.stamp;
  assign head_object  = rsp_data.head.object;
  assign head_outlet  = rsp_data.head.outlet;
  assign head_message = rsp_data.head.message;

endmodule

`default_nettype wire

/* src/tomq_checker.sv */
// Port-level checker for the timestamp-ordered message queue, bound to the top.
// Depends on tomq_pkg for the opcode and status codes.
`default_nettype none

module tomq_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_stall,
  input logic [1:0]  opcode,
  input logic        rsp_valid,
  input logic        rsp_stall,
  input logic [1:0]  status,
  input logic [6:0]  entry_count,
  input logic        is_empty,
  input logic [31:0] head_stamp,
  input logic [15:0] head_object,
  input logic [7:0]  head_outlet,
  input logic [15:0] head_message
);

  // An empty queue reports a zero count.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> entry_count == 7'd0)
    else $error("empty result with nonzero count");

  // An empty queue reports an all-zero head entry.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |->
      head_stamp == 32'd0 && head_object == 16'd0 &&
      head_outlet == 8'd0 && head_message == 16'd0)
    else $error("empty result with nonzero head");

  // A pop on an empty queue leaves it empty.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == tomq_pkg::STS_EMPTY |-> is_empty)
    else $error("pop-on-empty status from a nonempty queue");

  // A taken remove is followed by a request stall while its first match is deleted.
  a_remove_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && opcode == tomq_pkg::OP_REMOVE |=> req_stall)
    else $error("request taken during a remove");

  // A stalled response holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=>
      rsp_valid && $stable(status) && $stable(entry_count) && $stable(head_stamp))
    else $error("stalled response changed");

endmodule

bind timestamp_ordered_message_queue_top tomq_checker u_tomq_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .opcode         (opcode),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .status         (status),
  .entry_count    (entry_count),
  .is_empty       (is_empty),
  .head_stamp     (head_stamp),
  .head_object    (head_object),
  .head_outlet    (head_outlet),
  .head_message   (head_message)
);

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for timestamp_ordered_message_queue_top.
// A scoreboard class predicts each response with its own sorted queue; tasks drive requests.
// Depends on tomq_pkg and the queue top level in src.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tomq_pkg::*;

  localparam int QUEUE_DEPTH  = DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1480;
  localparam int PHASE_LEN    = 150;

  // The scoreboard keeps its own copy of the queue contents, head first. Each
  // accepted request updates that copy and queues the response the block owes
  // for it. Responses come back in request order, so the oldest one is compared.
  class queue_scoreboard;
    entry_t  held[$];
    result_t owed[$];
    int      mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    function void note_request(opcode_t op, entry_t e);
      result_t r;
      int      pos;
      r.status = STS_OK;
      case (op)
        OP_INSERT: begin
          if (held.size() >= QUEUE_DEPTH) begin
            r.status = STS_FULL;
          end else begin
            // A new entry goes behind every entry with an equal or earlier time.
            pos = held.size();
            for (int i = 0; i < held.size(); i++) begin
              if (e.stamp < held[i].stamp) begin
                pos = i;
                break;
              end
            end
            held.insert(pos, e);
          end
        end
        OP_REMOVE: begin
          // Only the first matching entry from the head is taken out.
          pos = -1;
          for (int i = 0; i < held.size(); i++) begin
            if (held[i].object == e.object && held[i].message == e.message &&
                held[i].outlet == e.outlet) begin
              pos = i;
              break;
            end
          end
          if (pos < 0) r.status = STS_NOT_FOUND;
          else held.delete(pos);
        end
        OP_POP: begin
          if (held.size() == 0) r.status = STS_EMPTY;
          else held.delete(0);
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(held.size());
      r.empty = (held.size() == 0);
      r.head  = (held.size() != 0) ? held[0] : '0;
      owed.insert(owed.size(), r);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (owed.size() == 0) begin
        report_mismatch($sformatf("response with no request outstanding, count=%0d",
                                  got.count));
        return;
      end
      want = owed[0];
      owed.delete(0);
      if (got.status !== want.status)
        report_mismatch($sformatf("status=%0d, expected %0d", got.status, want.status));
      if (got.count !== want.count)
        report_mismatch($sformatf("entry_count=%0d, expected %0d", got.count, want.count));
      if (got.empty !== want.empty)
        report_mismatch($sformatf("is_empty=%0b, expected %0b", got.empty, want.empty));
      if (got.head.stamp !== want.head.stamp)
        report_mismatch($sformatf("head_stamp=%h, expected %h",
                                  got.head.stamp, want.head.stamp));
      if (got.head.object !== want.head.object)
        report_mismatch($sformatf("head_object=%h, expected %h",
                                  got.head.object, want.head.object));
      if (got.head.outlet !== want.head.outlet)
        report_mismatch($sformatf("head_outlet=%h, expected %h",
                                  got.head.outlet, want.head.outlet));
      if (got.head.message !== want.head.message)
        report_mismatch($sformatf("head_message=%h, expected %h",
                                  got.head.message, want.head.message));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  opcode = OP_NOP;
  logic [31:0] stamp = '0;
  logic [15:0] object_id = '0;
  logic [7:0]  outlet_number = '0;
  logic [15:0] message_handle = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [1:0]  status;
  logic [6:0]  entry_count;
  logic        is_empty;
  logic [31:0] head_stamp;
  logic [15:0] head_object;
  logic [7:0]  head_outlet;
  logic [15:0] head_message;

  queue_scoreboard scoreboard = new();
  int              requests_sent = 0;
  result_t         observed;

  timestamp_ordered_message_queue_top #(.DEPTH(QUEUE_DEPTH)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .opcode        (opcode),
    .stamp         (stamp),
    .object_id     (object_id),
    .outlet_number (outlet_number),
    .message_handle(message_handle),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .entry_count   (entry_count),
    .is_empty      (is_empty),
    .head_stamp    (head_stamp),
    .head_object   (head_object),
    .head_outlet   (head_outlet),
    .head_message  (head_message)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Offers one request. Inputs change only at the falling edge; the request is
  // taken at the first rising edge with req_stall low, and only then does the
  // scoreboard learn of it. The sender idles at random, except for a stretch in
  // the middle of the run where requests go back to back.
  task automatic send_request(opcode_t op, logic [31:0] t, logic [15:0] obj,
                              logic [7:0] outlet, logic [15:0] msg);
    entry_t e;
    e.stamp   = t;
    e.object  = obj;
    e.outlet  = outlet;
    e.message = msg;
    @(negedge clk);
    if (requests_sent < 900 || requests_sent >= 1100) begin
      while ($urandom_range(99) < 35) begin
        req_valid <= 1'b0;
        @(negedge clk);
      end
    end
    req_valid      <= 1'b1;
    opcode         <= op;
    stamp          <= t;
    object_id      <= obj;
    outlet_number  <= outlet;
    message_handle <= msg;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    scoreboard.note_request(op, e);
    requests_sent++;
  endtask

  // Response side. Stalls at random, with one long hold-off partway through so
  // that the block backs up and must stall its request port, and with a quiet
  // stretch that lines up with the sender's back-to-back stretch.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!hold_done && requests_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (requests_sent >= 900 && requests_sent < 1100) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(99) < 35);
      end
    end
  end

  // Every response taken at a rising edge goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      observed.status       = status_t'(status);
      observed.count        = entry_count;
      observed.empty        = is_empty;
      observed.head.stamp   = head_stamp;
      observed.head.object  = head_object;
      observed.head.outlet  = head_outlet;
      observed.head.message = head_message;
      scoreboard.check_result(observed);
    end
  end

  initial begin
    opcode_t     op;
    entry_t      e;
    int          roll;
    int          phase;
    int          insert_pct;
    int          remove_pct;
    int          pop_pct;
    int          pick;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: the empty-queue cases first, then field extremes, equal
    // times that must keep arrival order, a duplicate entry where only the first
    // copy is removed, near misses on remove, no-op requests, and a final
    // drain that runs one pop past empty.
    send_request(OP_POP,    32'h0,         16'h0,    8'h0,  16'h0);
    send_request(OP_REMOVE, 32'h0,         16'h0,    8'h0,  16'h0);
    send_request(OP_NOP,    32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(OP_INSERT, 32'h0,         16'h0,    8'h0,  16'h0);
    send_request(OP_INSERT, 32'd100,       16'd1,    8'd1,  16'd1);
    send_request(OP_INSERT, 32'd100,       16'd2,    8'd2,  16'd2);
    send_request(OP_INSERT, 32'd100,       16'd1,    8'd1,  16'd1);
    send_request(OP_INSERT, 32'd100,       16'd3,    8'd3,  16'd3);
    send_request(OP_REMOVE, 32'h0,         16'd1,    8'd1,  16'd1);
    send_request(OP_REMOVE, 32'h0,         16'd1,    8'd2,  16'd1);
    send_request(OP_REMOVE, 32'h0,         16'd2,    8'd2,  16'd3);
    send_request(OP_REMOVE, 32'h0,         16'd3,    8'd3,  16'd2);
    send_request(OP_NOP,    32'h0,         16'h0,    8'h0,  16'h0);
    send_request(OP_POP,    32'h0,         16'h0,    8'h0,  16'h0);
    send_request(OP_INSERT, 32'h0,         16'hA5A5, 8'h5A, 16'h5A5A);
    send_request(OP_REMOVE, 32'h0,         16'hFFFF, 8'hFF, 16'hFFFF);
    repeat (5) send_request(OP_POP, 32'h0, 16'h0, 8'h0, 16'h0);

    // Random part. Phases rotate between filling (enough inserts to reach a full
    // queue and keep hitting it), a mixed load, and draining (down to empty and
    // pops past it). Handles often come from a tiny pool so that duplicates and
    // near misses are common, and most removes name an entry that is held.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / PHASE_LEN) % 3;
      case (phase)
        0:       begin insert_pct = 80; remove_pct = 8;  pop_pct = 8;  end
        1:       begin insert_pct = 48; remove_pct = 24; pop_pct = 24; end
        default: begin insert_pct = 20; remove_pct = 38; pop_pct = 38; end
      endcase
      roll = $urandom_range(99);
      if (roll < insert_pct)                               op = OP_INSERT;
      else if (roll < insert_pct + remove_pct)             op = OP_REMOVE;
      else if (roll < insert_pct + remove_pct + pop_pct)   op = OP_POP;
      else                                                 op = OP_NOP;

      case ($urandom_range(4))
        0, 1: e.stamp = $urandom;
        2:    e.stamp = $urandom_range(15);
        3:    e.stamp = 32'hFFFF_FFFF - $urandom_range(15);
        default: begin
          // Reuse a held time to force a tie.
          if (scoreboard.held.size() != 0)
            e.stamp = scoreboard.held[$urandom_range(scoreboard.held.size() - 1)].stamp;
          else
            e.stamp = $urandom;
        end
      endcase
      e.object  = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
      e.outlet  = $urandom_range(1) ? 8'($urandom)  : 8'($urandom_range(3));
      e.message = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));

      if (op == OP_REMOVE && scoreboard.held.size() != 0 && $urandom_range(99) < 85) begin
        e = scoreboard.held[$urandom_range(scoreboard.held.size() - 1)];
        // Now and then spoil one field by a single bit for a near miss.
        if ($urandom_range(99) < 20) begin
          pick = $urandom_range(2);
          case (pick)
            0:       e.object  ^= 16'(1 << $urandom_range(15));
            1:       e.outlet  ^= 8'(1 << $urandom_range(7));
            default: e.message ^= 16'(1 << $urandom_range(15));
          endcase
        end
      end
      send_request(op, e.stamp, e.object, e.outlet, e.message);
    end

    @(negedge clk);
    req_valid <= 1'b0;

    // Let the owed responses drain, then a few more cycles to catch any extra.
    for (int w = 0; w < 20000 && scoreboard.owed.size() != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (scoreboard.owed.size() != 0)
      scoreboard.report_mismatch($sformatf("%0d responses never arrived",
                                           scoreboard.owed.size()));
    if (scoreboard.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
